// ===== sv/msil_pkg.sv =====
// shared types, codes and sizes for the mode select integer list
package msil_pkg;

    localparam int CAPACITY_DEFAULT = 64;

    localparam int KIND_W = 2;
    localparam int VALUE_W = 32;
    localparam int MODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int ENTRY_COUNT_W = 7;
    localparam int OUT_DATA_W = 48;

    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [MODE_W-1:0] MODE_STACK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUEUE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SORTED = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_FULL,
        CMD_EMPTY,
        CMD_CLEAR,
        CMD_PUSH_HEAD,
        CMD_PUSH_TAIL,
        CMD_SORT_START,
        CMD_SORT_SHIFT,
        CMD_SORT_PLACE,
        CMD_SORT_HEAD,
        CMD_POP_READ,
        CMD_POP_DONE,
        CMD_LOAD_OUT
    } dp_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              empty;
        logic              greater;
        logic              pos_zero;
    } dp_stat_t;

endpackage

// ===== sv/msil_dp.sv =====
// datapath: list storage, pointers, count, mode register and result registers
module msil_dp #(
    parameter int CAPACITY = msil_pkg::CAPACITY_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  msil_pkg::dp_cmd_t                   cmd,
    input  logic [msil_pkg::VALUE_W-1:0]        in_value,
    input  logic [msil_pkg::KIND_W-1:0]         in_kind,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [msil_pkg::MODE_W-1:0]         cfg_data,
    output msil_pkg::dp_stat_t                  stat,
    output logic [msil_pkg::OUT_DATA_W-1:0]     out_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int VW = msil_pkg::VALUE_W;
    localparam int ECW = msil_pkg::ENTRY_COUNT_W;

    logic [VW-1:0]                    store_reg [CAPACITY];
    logic [VW-1:0]                    rd_data_reg;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [IDX_W-1:0]                 head_reg, head_next;
    logic [IDX_W-1:0]                 pos_reg, pos_next;
    logic [msil_pkg::MODE_W-1:0]      mode_reg, mode_next;
    logic [msil_pkg::KIND_W-1:0]      kind_reg;
    logic [VW-1:0]                    value_reg;
    logic [VW-1:0]                    popped_reg;
    logic [msil_pkg::STATUS_W-1:0]    status_reg;
    logic [msil_pkg::OUT_DATA_W-1:0]  out_data_reg;

    logic              we;
    logic [IDX_W-1:0]  wr_addr;
    logic [VW-1:0]     wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [CNT_W-1:0]  count_m1;
    logic [IDX_W-1:0]  head_dec;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  pos_dec;
    logic [CNT_W+ECW-1:0] count_wide;
    logic              cfg_write;

    // logical position to physical address in the circular store
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [IDX_W-1:0] offs);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= (IDX_W+1)'(CAPACITY))
        begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign cfg_write = cfg_valid && cfg_ready;
    assign count_m1 = count_reg - CNT_W'(1);
    assign head_dec = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - IDX_W'(1);
    assign head_inc = (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + IDX_W'(1);
    assign pos_dec = (pos_reg == '0) ? '0 : pos_reg - IDX_W'(1);
    assign count_wide = {{ECW{1'b0}}, count_reg};

    always_comb
    begin
        we = 1'b0;
        wr_addr = head_reg;
        wr_data = value_reg;
        rd_addr = head_reg;
        count_next = count_reg;
        head_next = head_reg;
        pos_next = pos_reg;
        mode_next = mode_reg;
        case (cmd)
            msil_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            msil_pkg::CMD_PUSH_HEAD:
            begin
                we = 1'b1;
                wr_addr = head_dec;
                head_next = head_dec;
                count_next = count_reg + CNT_W'(1);
            end
            msil_pkg::CMD_PUSH_TAIL:
            begin
                we = 1'b1;
                wr_addr = phys(head_reg, count_reg[IDX_W-1:0]);
                count_next = count_reg + CNT_W'(1);
            end
            msil_pkg::CMD_SORT_START:
            begin
                pos_next = count_m1[IDX_W-1:0];
                rd_addr = phys(head_reg, count_m1[IDX_W-1:0]);
            end
            msil_pkg::CMD_SORT_SHIFT:
            begin
                we = 1'b1;
                wr_addr = phys(head_reg, pos_reg + IDX_W'(1));
                wr_data = rd_data_reg;
                pos_next = pos_dec;
                rd_addr = phys(head_reg, pos_dec);
            end
            msil_pkg::CMD_SORT_PLACE:
            begin
                we = 1'b1;
                wr_addr = phys(head_reg, pos_reg + IDX_W'(1));
                count_next = count_reg + CNT_W'(1);
            end
            msil_pkg::CMD_SORT_HEAD:
            begin
                we = 1'b1;
                wr_addr = head_reg;
                count_next = count_reg + CNT_W'(1);
            end
            msil_pkg::CMD_POP_DONE:
            begin
                head_next = head_inc;
                count_next = count_m1;
            end
            default:
            begin
            end
        endcase
        if (cfg_write)
        begin
            mode_next = cfg_data;
            count_next = '0;
            head_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg <= '0;
            pos_reg <= '0;
            mode_reg <= msil_pkg::MODE_QUEUE;
        end
        else
        begin
            count_reg <= count_next;
            head_reg <= head_next;
            pos_reg <= pos_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            msil_pkg::CMD_LATCH:
            begin
                kind_reg <= in_kind;
                value_reg <= in_value;
                popped_reg <= '0;
                status_reg <= msil_pkg::STATUS_OK;
            end
            msil_pkg::CMD_FULL:
            begin
                status_reg <= msil_pkg::STATUS_FULL;
            end
            msil_pkg::CMD_EMPTY:
            begin
                status_reg <= msil_pkg::STATUS_EMPTY;
            end
            msil_pkg::CMD_POP_DONE:
            begin
                popped_reg <= rd_data_reg;
            end
            msil_pkg::CMD_LOAD_OUT:
            begin
                out_data_reg <= {6'b0, (count_reg == '0), count_wide[ECW-1:0],
                                 status_reg, popped_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign stat.kind = kind_reg;
    assign stat.mode = mode_reg;
    assign stat.full = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty = (count_reg == '0);
    assign stat.greater = ($signed(rd_data_reg) > $signed(value_reg));
    assign stat.pos_zero = (pos_reg == '0);
    assign out_data = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("stored count above capacity");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == msil_pkg::CMD_POP_DONE |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not remove one entry");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> count_reg == '0)
        else $error("mode write did not empty the list");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == msil_pkg::CMD_PUSH_HEAD || cmd == msil_pkg::CMD_PUSH_TAIL ||
         cmd == msil_pkg::CMD_SORT_PLACE || cmd == msil_pkg::CMD_SORT_HEAD)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not add one entry");

endmodule

// ===== sv/msil_ctrl.sv =====
// controller: sequences each list operation and the output handshake
module msil_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic                cfg_ready,
    input  msil_pkg::dp_stat_t  stat,
    output msil_pkg::dp_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_SORT,
        ST_SORT_HEAD,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = msil_pkg::CMD_NONE;
        m_valid_next = m_valid_reg && !m_axis_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd = msil_pkg::CMD_LATCH;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (stat.kind)
                    msil_pkg::KIND_PUSH:
                    begin
                        if (stat.full)
                        begin
                            cmd = msil_pkg::CMD_FULL;
                        end
                        else
                        begin
                            case (stat.mode)
                                msil_pkg::MODE_STACK:
                                begin
                                    cmd = msil_pkg::CMD_PUSH_HEAD;
                                end
                                msil_pkg::MODE_SORTED:
                                begin
                                    if (stat.empty)
                                    begin
                                        cmd = msil_pkg::CMD_PUSH_TAIL;
                                    end
                                    else
                                    begin
                                        cmd = msil_pkg::CMD_SORT_START;
                                        state_next = ST_SORT;
                                    end
                                end
                                default:
                                begin
                                    cmd = msil_pkg::CMD_PUSH_TAIL;
                                end
                            endcase
                        end
                    end
                    msil_pkg::KIND_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd = msil_pkg::CMD_EMPTY;
                        end
                        else
                        begin
                            cmd = msil_pkg::CMD_POP_READ;
                            state_next = ST_POP;
                        end
                    end
                    msil_pkg::KIND_CLEAR:
                    begin
                        cmd = msil_pkg::CMD_CLEAR;
                    end
                    default:
                    begin
                        cmd = msil_pkg::CMD_NONE;
                    end
                endcase
            end
            ST_POP:
            begin
                cmd = msil_pkg::CMD_POP_DONE;
                state_next = ST_DONE;
            end
            ST_SORT:
            begin
                // walk from the tail toward the head, moving larger values up
                if (stat.greater)
                begin
                    cmd = msil_pkg::CMD_SORT_SHIFT;
                    if (stat.pos_zero)
                    begin
                        state_next = ST_SORT_HEAD;
                    end
                end
                else
                begin
                    cmd = msil_pkg::CMD_SORT_PLACE;
                    state_next = ST_DONE;
                end
            end
            ST_SORT_HEAD:
            begin
                cmd = msil_pkg::CMD_SORT_HEAD;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    cmd = msil_pkg::CMD_LOAD_OUT;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("word accepted while another is in flight");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == msil_pkg::CMD_LOAD_OUT |=> m_axis_tvalid)
        else $error("result loaded but not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == msil_pkg::CMD_LOAD_OUT |-> (!m_valid_reg || m_axis_tready))
        else $error("pending result overwritten");

endmodule

// ===== sv/mode_select_int_list.sv =====
// top level of the mode select integer list
// bounded list of signed 32-bit values ordered as stack, queue or sorted
// input stream: tuser carries the operation (push, pop head, clear),
// tdata the value to push; every word gives one result word
// output stream: popped value, status, entry count and empty flag
// config channel: cfg_data sets the ordering mode and empties the list;
// it is taken only while no operation is in flight
// one word is worked at a time: after the word is latched, an execute
// state does a push to stack or queue, a clear or a refused operation;
// a pop adds a state for its registered storage read, and a sorted push
// into a non-empty list walks from the tail, shifting each stored value
// greater than the new one up one entry a cycle through the single
// write port, then places the new value; a done state loads the result
// a new word can be taken in the cycle after the result is loaded
// the output register lets the next word be taken while a result waits;
// a stalled receiver holds the block before it loads the next result
// reset empties the list and selects queue mode; storage is not cleared
module mode_select_int_list #(
    parameter int CAPACITY = msil_pkg::CAPACITY_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // push_value
    input  logic [msil_pkg::VALUE_W-1:0]     s_axis_tdata,
    // kind
    input  logic [msil_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // popped_value, status, entry_count, is_empty, zero fill
    output logic [msil_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    // list_mode
    input  logic [msil_pkg::MODE_W-1:0]      cfg_data
);

    msil_pkg::dp_cmd_t  cmd;
    msil_pkg::dp_stat_t stat;

    msil_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_ready     (cfg_ready),
        .stat          (stat),
        .cmd           (cmd)
    );

    msil_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_value  (s_axis_tdata),
        .in_kind   (s_axis_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== test/tb_mode_select_int_list.sv =====
`timescale 1ns / 100ps
// self-checking stream testbench for the mode select integer list
module tb_mode_select_int_list;

    localparam int CAPACITY = msil_pkg::CAPACITY_DEFAULT;
    localparam logic [msil_pkg::KIND_W-1:0] KIND_NOP = 2'd3;
    localparam logic [msil_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int PHASE_OPS = 155;
    localparam int NUM_PHASES = 8;
    localparam int STATUS_LSB = msil_pkg::VALUE_W;
    localparam int COUNT_LSB = STATUS_LSB + msil_pkg::STATUS_W;
    localparam int EMPTY_BIT = COUNT_LSB + msil_pkg::ENTRY_COUNT_W;

    typedef struct packed {
        logic [msil_pkg::KIND_W-1:0]  kind;
        logic [msil_pkg::VALUE_W-1:0] value;
    } list_op_t;

    typedef struct packed {
        logic [msil_pkg::VALUE_W-1:0]       popped;
        logic [msil_pkg::STATUS_W-1:0]      status;
        logic [msil_pkg::ENTRY_COUNT_W-1:0] count;
        logic                               empty;
    } list_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [msil_pkg::VALUE_W-1:0]    s_axis_tdata = '0;
    logic [msil_pkg::KIND_W-1:0]     s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [msil_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [msil_pkg::MODE_W-1:0]     cfg_data = '0;

    list_op_t                            queued_ops[$];
    list_result_t                        predicted_words[$];
    logic signed [msil_pkg::VALUE_W-1:0] model_list[$];
    logic [msil_pkg::MODE_W-1:0]         model_mode = msil_pkg::MODE_QUEUE;
    logic                                word_taken = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int words_checked = 0;
    int ops_queued = 0;
    int mode_writes = 0;
    int full_refusals = 0;
    int empty_pops = 0;

    logic [msil_pkg::VALUE_W-1:0] extreme_vals[5] = '{32'h8000_0000, 32'h7fff_ffff,
                                                     32'h0000_0000, 32'hffff_ffff,
                                                     32'h0000_0001};

    mode_select_int_list #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic list_result_t predict_list_op(list_op_t op);
        list_result_t res;
        int pos;
        res = '0;
        case (op.kind)
            msil_pkg::KIND_PUSH:
            begin
                if (model_list.size() >= CAPACITY)
                begin
                    res.status = msil_pkg::STATUS_FULL;
                    full_refusals++;
                end
                else if (model_mode == msil_pkg::MODE_STACK)
                    model_list.push_front(op.value);
                else if (model_mode == msil_pkg::MODE_SORTED)
                begin
                    // new value lands after any equal ones
                    pos = 0;
                    while (pos < model_list.size() && !($signed(op.value) < model_list[pos]))
                        pos++;
                    model_list.insert(pos, op.value);
                end
                else
                    model_list.push_back(op.value);
            end
            msil_pkg::KIND_POP:
            begin
                if (model_list.size() == 0)
                begin
                    res.status = msil_pkg::STATUS_EMPTY;
                    empty_pops++;
                end
                else
                    res.popped = model_list.pop_front();
            end
            msil_pkg::KIND_CLEAR:
                model_list.delete();
            default: ;
        endcase
        res.count = msil_pkg::ENTRY_COUNT_W'(model_list.size());
        res.empty = (model_list.size() == 0);
        return res;
    endfunction

    task automatic check_field(string name, logic [msil_pkg::VALUE_W-1:0] exp_val,
                               logic [msil_pkg::VALUE_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
        end
    endtask

    // driver: new word at the falling edge once the previous one is taken
    always @(negedge clk)
    begin : driver
        list_op_t op;
        if (rst_n)
        begin
            if (!s_axis_tvalid || word_taken)
            begin
                if (queued_ops.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    op = queued_ops.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= op.kind;
                    s_axis_tdata <= op.value;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    s_axis_tdata <= $urandom();
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predicts on accepted words, checks result words
    always @(posedge clk)
    begin : monitor
        list_op_t     op;
        list_result_t exp_word;
        list_result_t act_word;
        if (rst_n)
        begin
            word_taken <= s_axis_tvalid && s_axis_tready;
            if (cfg_valid && cfg_ready)
            begin
                model_mode = cfg_data;
                model_list.delete();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                op.kind = s_axis_tuser;
                op.value = s_axis_tdata;
                predicted_words.push_back(predict_list_op(op));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                act_word.popped = m_axis_tdata[msil_pkg::VALUE_W-1:0];
                act_word.status = m_axis_tdata[COUNT_LSB-1:STATUS_LSB];
                act_word.count = m_axis_tdata[EMPTY_BIT-1:COUNT_LSB];
                act_word.empty = m_axis_tdata[EMPTY_BIT];
                if (predicted_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word, actual %h", $time, m_axis_tdata);
                end
                else
                begin
                    exp_word = predicted_words.pop_front();
                    check_field("popped_value", exp_word.popped, act_word.popped);
                    check_field("status", exp_word.status, act_word.status);
                    check_field("entry_count", exp_word.count, act_word.count);
                    check_field("is_empty", exp_word.empty, act_word.empty);
                    words_checked++;
                end
            end
        end
    end

    function automatic logic [msil_pkg::VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        // narrow range gives plenty of equal values for sorted mode
        if (sel < 40)
            return $urandom_range(8) - 4;
        if (sel < 55)
            return extreme_vals[$urandom_range(4)];
        return $urandom();
    endfunction

    task automatic queue_op(logic [msil_pkg::KIND_W-1:0] kind,
                            logic [msil_pkg::VALUE_W-1:0] value);
        list_op_t op;
        op.kind = kind;
        op.value = value;
        queued_ops.push_back(op);
        ops_queued++;
    endtask

    task automatic wait_drained();
        while (words_checked != ops_queued)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_mode(logic [msil_pkg::MODE_W-1:0] mode);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data <= msil_pkg::MODE_W'($urandom());
        mode_writes++;
    endtask

    task automatic run_phase(logic [msil_pkg::MODE_W-1:0] mode, int idle_sel);
        int n;
        int burst;
        int sel;
        send_idle_pct = (idle_sel == 1) ? 86 : (idle_sel == 3) ? 30 : 0;
        recv_stall_pct = (idle_sel == 2) ? 86 : (idle_sel == 3) ? 30 : 0;
        write_mode(mode);
        n = 0;
        while (n < PHASE_OPS)
        begin
            sel = $urandom_range(99);
            if (sel < 5)
            begin
                // fill run, usually reaches the full list
                burst = $urandom_range(70, 50);
                repeat (burst) queue_op(msil_pkg::KIND_PUSH, pick_value());
                n += burst;
            end
            else if (sel < 10)
            begin
                burst = $urandom_range(70, 10);
                repeat (burst) queue_op(msil_pkg::KIND_POP, $urandom());
                n += burst;
            end
            else
            begin
                if (sel < 55)
                    queue_op(msil_pkg::KIND_PUSH, pick_value());
                else if (sel < 85)
                    queue_op(msil_pkg::KIND_POP, $urandom());
                else if (sel < 92)
                    queue_op(msil_pkg::KIND_CLEAR, $urandom());
                else
                    queue_op(KIND_NOP, $urandom());
                n++;
            end
        end
        wait_drained();
    endtask

    initial
    begin : stimulus
        logic [msil_pkg::MODE_W-1:0] phase_modes[NUM_PHASES];
        phase_modes = '{msil_pkg::MODE_SORTED, msil_pkg::MODE_STACK, MODE_SPARE,
                        msil_pkg::MODE_QUEUE, msil_pkg::MODE_SORTED, msil_pkg::MODE_STACK,
                        msil_pkg::MODE_QUEUE, MODE_SPARE};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words in the queue mode left by reset
        queue_op(msil_pkg::KIND_POP, 32'h1234_5678);
        queue_op(msil_pkg::KIND_PUSH, 32'h8000_0000);
        queue_op(msil_pkg::KIND_PUSH, 32'h7fff_ffff);
        queue_op(msil_pkg::KIND_PUSH, 32'h0000_0000);
        queue_op(msil_pkg::KIND_PUSH, 32'hffff_ffff);
        queue_op(msil_pkg::KIND_PUSH, 32'h0000_0001);
        queue_op(KIND_NOP, 32'hffff_ffff);
        queue_op(msil_pkg::KIND_POP, 32'hffff_ffff);
        queue_op(msil_pkg::KIND_POP, 32'h0000_0000);
        queue_op(msil_pkg::KIND_CLEAR, 32'hffff_ffff);
        queue_op(msil_pkg::KIND_POP, 32'h0000_0000);
        queue_op(KIND_NOP, 32'h0000_0000);
        queue_op(msil_pkg::KIND_PUSH, 32'h0000_0005);
        queue_op(msil_pkg::KIND_PUSH, 32'h0000_0005);
        queue_op(msil_pkg::KIND_POP, 32'h0000_0000);
        queue_op(msil_pkg::KIND_POP, 32'h0000_0000);
        queue_op(msil_pkg::KIND_POP, 32'h0000_0000);
        queue_op(msil_pkg::KIND_CLEAR, 32'h0000_0000);
        wait_drained();

        for (int i = 0; i < NUM_PHASES; i++)
            run_phase(phase_modes[i], (i + i / 4) % 4);

        repeat (20) @(negedge clk);
        if (predicted_words.size() != 0)
            errors++;
        $display("ran %0d list operations under %0d mode writes, %0d result words checked",
                 ops_queued, mode_writes, words_checked);
        $display("%0d pushes refused on a full list, %0d pops on an empty list",
                 full_refusals, empty_pops);
        if (errors == 0)
            $display("tb_mode_select_int_list OK");
        else
            $display("tb_mode_select_int_list NOT OK");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("%0t: timeout, %0d of %0d result words seen", $time, words_checked, ops_queued);
        $display("tb_mode_select_int_list NOT OK");
        $finish;
    end

endmodule
